// ===== rtl/vmd_pkg.sv =====
// Shared definitions for the vehicle magnetic detector core.
// Holds register index codes, register widths, reset values and the result type.
// No dependencies.
package vmd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEV_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_QUIET_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_BASELINE_GAIN = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int THR_W  = 15;
    localparam int TOUT_W = 8;
    localparam int GAIN_W = 16;

    // The gain is Q0.16 regardless of the baseline fraction width.
    localparam int GAIN_FRAC = 16;

    localparam logic [THR_W-1:0]  THR_RESET  = 15'd8;
    localparam logic [TOUT_W-1:0] TOUT_RESET = 8'd20;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd328;

    // Calibration counter width; covers sample counts up to 63.
    localparam int CNT_W = 6;

    typedef struct packed {
        logic calibrating;
        logic exceeds;
        logic event_active;
        logic car_reported;
        logic direction_in;
    } vmd_result_t;

endpackage

// ===== rtl/vehicle_magnetic_detector_core.sv =====
// Vehicle magnetic detector core: calibration, baseline tracking and direction decision.
// Depends on vmd_pkg for register codes, widths and the result type.
//
// Usage
// Sample requests arrive on the s_ channel (valid/ready) as a pair of signed
// magnetometer readings: a detection axis and a direction axis. Every request
// produces exactly one result request on the m_ channel, in order.
// The first CAL_COUNT requests calibrate: they are summed and both baselines are
// loaded with the truncated mean; their results carry only the calibrating flag.
// Afterwards a detection deviation beyond the threshold opens an event, three
// direction readings are collected, and the next exceeding sample reports the
// car direction from their median. Quiet samples outside an event track the
// baselines with an exponential average.
// Path: an accepted request waits in the input register and is processed from
// there into the result register, which drives m_valid.
// Throughput: one request per cycle unless m_ready holds the result register;
// all per-sample work (one 33x17 multiply and one reciprocal multiply per axis
// for the calibration mean, a 3-entry median) is combinational between the two registers.
// Stalls: the result register holds while m_ready is low; the input register
// still takes one more request, after which s_ready drops until the result
// drains. Configuration writes land on cfg_we and are taken at once.
// Reset (aresetn low, synchronous) restores register defaults and restarts
// calibration; no clearing pass is needed.
module vehicle_magnetic_detector_core
    import vmd_pkg::*;
#(
    parameter int CAL_COUNT   = 40,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_mag_sample,
    input  logic [SAMPLE_BITS-1:0] s_dir_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_calibrating,
    output logic                   m_exceeds,
    output logic                   m_event_active,
    output logic                   m_car_reported,
    output logic                   m_direction_in
);

    // Baseline width: integer sample bits plus fraction bits.
    localparam int BW     = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    // Magnitude bits of a calibration sum.
    localparam int MAG_W  = SAMPLE_BITS + CNT_W - 1;
    // Exact reciprocal for floor division by CAL_COUNT over MAG_W-bit values.
    localparam int DIV_L  = $clog2(CAL_COUNT);
    localparam int DIV_SH = MAG_W + DIV_L;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_SH) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
    localparam int RCP_W  = MAG_W + 2;
    localparam int PRD_W  = MAG_W + RCP_W;
    // Deviation compare width, wide enough for both sides.
    localparam int CMP_W  = BW + 16;
    localparam int EPRD_W = BW + 1 + GAIN_W + 1;

    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_COUNT - 1);
    localparam logic [CNT_W-1:0] CAL_END  = CNT_W'(CAL_COUNT);

    // Configuration registers.
    logic [THR_W-1:0]  thr_reg;
    logic [TOUT_W-1:0] tout_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Input stage.
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_mag_reg;
    logic signed [SAMPLE_BITS-1:0] in_dir_reg;

    // Detector state.
    logic [CNT_W-1:0]              cal_cnt_reg,    cal_cnt_next;
    logic signed [SUM_W-1:0]       mag_sum_reg,    mag_sum_next;
    logic signed [SUM_W-1:0]       dir_sum_reg,    dir_sum_next;
    logic signed [BW-1:0]          mag_base_reg,   mag_base_next;
    logic signed [BW-1:0]          dir_base_reg,   dir_base_next;
    logic                          event_reg,      event_next;
    logic                          reported_reg,   reported_next;
    logic [TOUT_W-1:0]             quiet_reg,      quiet_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [3];
    logic [1:0]                    fill_reg,       fill_next;
    logic signed [SAMPLE_BITS-1:0] prev_dir_reg;

    // Result stage.
    logic        out_valid_reg;
    vmd_result_t res_reg, res_next;

    logic fire;
    logic win_we;
    logic signed [SAMPLE_BITS-1:0] win_wdata;

    logic signed [SAMPLE_BITS-1:0] mag_mean, dir_mean;
    logic signed [BW-1:0]          mag_ema, dir_ema;
    logic signed [BW:0]            dev;
    logic [BW:0]                   dev_abs;
    logic                          exceeds;
    logic signed [SAMPLE_BITS-1:0] med_lo, med_hi, median;
    logic                          dir_in;

    // Mean of a calibration sum, truncated toward zero. The reciprocal is exact
    // for every magnitude a sum can reach, so no correction step follows.
    function automatic logic signed [SAMPLE_BITS-1:0] cal_mean(
        input logic signed [SUM_W-1:0] sum
    );
        logic [SUM_W-1:0] mag_full;
        logic [MAG_W-1:0] mag;
        logic [PRD_W-1:0] prod;
        logic [MAG_W-1:0] quot;
        logic [SAMPLE_BITS-1:0] q_trim;
        mag_full = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
        mag      = mag_full[MAG_W-1:0];
        prod     = PRD_W'(mag) * PRD_W'(RCP_W'(DIV_M));
        quot     = MAG_W'(prod >> DIV_SH);
        q_trim   = quot[SAMPLE_BITS-1:0];
        return sum[SUM_W-1] ? $signed(~q_trim + 1'b1) : $signed(q_trim);
    endfunction

    // base + floor((sample * 2^FRAC_BITS - base) * gain / 2^16)
    function automatic logic signed [BW-1:0] ema(
        input logic signed [BW-1:0]          base,
        input logic signed [SAMPLE_BITS-1:0] sample,
        input logic [GAIN_W-1:0]             gain
    );
        logic signed [BW:0]     target;
        logic signed [BW:0]     diff;
        logic signed [EPRD_W-1:0] prod;
        logic signed [EPRD_W-1:0] step;
        target = {sample[SAMPLE_BITS-1], sample, {FRAC_BITS{1'b0}}};
        diff   = target - {base[BW-1], base};
        prod   = EPRD_W'(diff) * $signed({1'b0, gain});
        step   = prod >>> GAIN_FRAC;
        return base + step[BW-1:0];
    endfunction

    // Handshake: the compute step fires when an input is held and the result
    // register is empty or draining this cycle.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            tout_reg <= TOUT_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEV_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                CFG_QUIET_TIMEOUT: tout_reg <= cfg_wdata[TOUT_W-1:0];
                CFG_BASELINE_GAIN: gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mag_reg <= $signed(s_mag_sample);
            in_dir_reg <= $signed(s_dir_sample);
        end
    end

    // Calibration means and baseline tracking, both computed from the held input.
    always_comb begin
        mag_sum_next = mag_sum_reg + SUM_W'(in_mag_reg);
        dir_sum_next = dir_sum_reg + SUM_W'(in_dir_reg);
        mag_mean     = cal_mean(mag_sum_next);
        dir_mean     = cal_mean(dir_sum_next);
        mag_ema      = ema(mag_base_reg, in_mag_reg, gain_reg);
        dir_ema      = ema(dir_base_reg, in_dir_reg, gain_reg);
    end

    // Deviation of the detection axis against the threshold, both in baseline units.
    always_comb begin
        dev     = {in_mag_reg[SAMPLE_BITS-1], in_mag_reg, {FRAC_BITS{1'b0}}}
                - {mag_base_reg[BW-1], mag_base_reg};
        dev_abs = dev[BW] ? $unsigned(-dev) : $unsigned(dev);
        exceeds = CMP_W'(dev_abs) > (CMP_W'(thr_reg) << FRAC_BITS);
    end

    // Median of the three collected direction readings.
    always_comb begin
        med_lo = (win_reg[0] < win_reg[1]) ? win_reg[0] : win_reg[1];
        med_hi = (win_reg[0] > win_reg[1]) ? win_reg[0] : win_reg[1];
        median = (med_hi < win_reg[2]) ? med_hi : win_reg[2];
        median = (med_lo > median) ? med_lo : median;
        dir_in = $signed({median, {FRAC_BITS{1'b0}}}) > dir_base_reg;
    end

    // One sample's state update and result.
    always_comb begin
        cal_cnt_next  = cal_cnt_reg;
        mag_base_next = mag_base_reg;
        dir_base_next = dir_base_reg;
        event_next    = event_reg;
        reported_next = reported_reg;
        quiet_next    = quiet_reg;
        fill_next     = fill_reg;
        win_we        = 1'b0;
        win_wdata     = in_dir_reg;
        res_next      = '0;

        if (cal_cnt_reg < CAL_END) begin
            // Calibration: count, accumulate, and load the baselines on the last one.
            cal_cnt_next         = cal_cnt_reg + 1'b1;
            res_next.calibrating = 1'b1;
            if (cal_cnt_reg == CAL_LAST) begin
                mag_base_next = {mag_mean, {FRAC_BITS{1'b0}}};
                dir_base_next = {dir_mean, {FRAC_BITS{1'b0}}};
            end
        end else begin
            res_next.exceeds = exceeds;
            if (exceeds) begin
                if (!reported_reg && fill_reg == 2'd3) begin
                    res_next.car_reported = 1'b1;
                    res_next.direction_in = dir_in;
                    reported_next         = 1'b1;
                    fill_next             = 2'd0;
                end else if (!reported_reg) begin
                    // The first entry of a window is the sample before the event.
                    win_we    = 1'b1;
                    win_wdata = (fill_reg == 2'd0) ? prev_dir_reg : in_dir_reg;
                    fill_next = fill_reg + 1'b1;
                end
                event_next = 1'b1;
                quiet_next = '0;
            end else if (event_reg) begin
                if (quiet_reg != {TOUT_W{1'b1}}) begin
                    quiet_next = quiet_reg + 1'b1;
                end
            end else begin
                mag_base_next = mag_ema;
                dir_base_next = dir_ema;
            end

            if (quiet_next >= tout_reg) begin
                event_next    = 1'b0;
                reported_next = 1'b0;
                quiet_next    = '0;
            end
            res_next.event_active = event_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_cnt_reg  <= '0;
            mag_sum_reg  <= '0;
            dir_sum_reg  <= '0;
            mag_base_reg <= '0;
            dir_base_reg <= '0;
            event_reg    <= 1'b0;
            reported_reg <= 1'b0;
            quiet_reg    <= '0;
            fill_reg     <= '0;
            prev_dir_reg <= '0;
        end else if (fire) begin
            cal_cnt_reg  <= cal_cnt_next;
            mag_base_reg <= mag_base_next;
            dir_base_reg <= dir_base_next;
            event_reg    <= event_next;
            reported_reg <= reported_next;
            quiet_reg    <= quiet_next;
            fill_reg     <= fill_next;
            prev_dir_reg <= in_dir_reg;
            if (cal_cnt_reg < CAL_END) begin
                mag_sum_reg <= mag_sum_next;
                dir_sum_reg <= dir_sum_next;
            end
        end
    end

    // Window entries are only read once all three have been written.
    always_ff @(posedge aclk) begin
        if (fire && win_we) begin
            win_reg[fill_reg] <= win_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_calibrating  = res_reg.calibrating;
    assign m_exceeds      = res_reg.exceeds;
    assign m_event_active = res_reg.event_active;
    assign m_car_reported = res_reg.car_reported;
    assign m_direction_in = res_reg.direction_in;

    // A direction is only ever stated together with a report.
    a_dir_needs_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_direction_in |-> m_car_reported)
        else $error("direction_in set without car_reported");

    // Calibration results carry no detection information.
    a_cal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_calibrating |-> !m_exceeds && !m_event_active && !m_car_reported)
        else $error("calibration result carries detection flags");

    // A report can only be pending inside an event.
    a_report_in_event: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg |-> event_reg)
        else $error("reported flag set outside an event");

    // Every compute step leaves a result in the output register.
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("processed sample produced no result");

    // The calibration counter saturates at the calibration length.
    a_cal_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_cnt_reg <= CAL_END)
        else $error("calibration counter out of range");

endmodule

// ===== tb/vmd_direction_checker.sv =====
`timescale 1ns / 1ps
// Checker for the vehicle magnetic detector core: mirrors calibration, baselines and events.
// Watches the configuration port and both request channels; depends on vmd_pkg.
module vmd_direction_checker
    import vmd_pkg::*;
#(
    parameter int CAL_COUNT   = 40,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_mag_sample,
    input  logic [SAMPLE_BITS-1:0] s_dir_sample,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_calibrating,
    input  logic                   m_exceeds,
    input  logic                   m_event_active,
    input  logic                   m_car_reported,
    input  logic                   m_direction_in,
    output int                     flag_mismatches,
    output int                     flags_outstanding
);

    localparam longint SCALE = longint'(1) << FRAC_BITS;

    logic [THR_W-1:0]  threshold;
    logic [TOUT_W-1:0] timeout;
    logic [GAIN_W-1:0] gain;

    int     cal_seen;
    longint mag_sum;
    longint dir_sum;
    longint mag_base;
    longint dir_base;
    bit     in_event;
    bit     reported;
    int     quiet_run;
    longint window [3];
    int     fill;
    longint prev_dir;

    vmd_result_t predicted_flags [$];

    localparam string FIELD_NAMES [5] = '{"calibrating", "exceeds", "event_active",
                                          "car_reported", "direction_in"};

    // Exponential average in Q.FRAC_BITS; the arithmetic shift floors toward minus infinity.
    function automatic longint track(input longint base, input longint sample);
        longint step;
        step = (sample * SCALE - base) * longint'(gain);
        return base + (step >>> GAIN_FRAC);
    endfunction

    function automatic longint median3(input longint a, input longint b, input longint c);
        longint lo;
        longint hi;
        lo = (a < b) ? a : b;
        hi = (a > b) ? a : b;
        hi = (hi < c) ? hi : c;
        return (lo > hi) ? lo : hi;
    endfunction

    task automatic advance_detector(input longint mag, input longint dir,
                                    output vmd_result_t res);
        longint dev;
        bit     over;
        res = '0;
        if (cal_seen < CAL_COUNT) begin
            cal_seen++;
            mag_sum += mag;
            dir_sum += dir;
            if (cal_seen == CAL_COUNT) begin
                mag_base = (mag_sum / CAL_COUNT) * SCALE;
                dir_base = (dir_sum / CAL_COUNT) * SCALE;
            end
            prev_dir = dir;
            res.calibrating = 1'b1;
            return;
        end
        dev = mag * SCALE - mag_base;
        if (dev < 0) begin
            dev = -dev;
        end
        over = dev > (longint'(threshold) * SCALE);
        if (over) begin
            if (!reported && fill >= 3) begin
                res.direction_in = median3(window[0], window[1], window[2]) * SCALE > dir_base;
                res.car_reported = 1'b1;
                reported = 1'b1;
                window = '{0, 0, 0};
                fill = 0;
            end else if (!reported) begin
                window[fill] = (fill == 0) ? prev_dir : dir;
                fill++;
            end
            in_event = 1'b1;
            quiet_run = 0;
        end else if (in_event) begin
            if (quiet_run < 255) begin
                quiet_run++;
            end
        end else begin
            mag_base = track(mag_base, mag);
            dir_base = track(dir_base, dir);
        end
        if (quiet_run >= int'(timeout)) begin
            in_event = 1'b0;
            reported = 1'b0;
            quiet_run = 0;
        end
        prev_dir = dir;
        res.exceeds = over;
        res.event_active = in_event;
    endtask

    always @(posedge aclk) begin
        vmd_result_t want;
        vmd_result_t got;
        if (!aresetn) begin
            threshold = THR_RESET;
            timeout = TOUT_RESET;
            gain = GAIN_RESET;
            cal_seen = 0;
            mag_sum = 0;
            dir_sum = 0;
            mag_base = 0;
            dir_base = 0;
            in_event = 1'b0;
            reported = 1'b0;
            quiet_run = 0;
            window = '{0, 0, 0};
            fill = 0;
            prev_dir = 0;
            predicted_flags.delete();
            flag_mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEV_THRESHOLD: threshold = cfg_wdata[THR_W-1:0];
                    CFG_QUIET_TIMEOUT: timeout = cfg_wdata[TOUT_W-1:0];
                    CFG_BASELINE_GAIN: gain = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_detector($signed(s_mag_sample), $signed(s_dir_sample), want);
                predicted_flags.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_calibrating, m_exceeds, m_event_active, m_car_reported,
                       m_direction_in};
                if (predicted_flags.size() == 0) begin
                    $display("%0t: result request with none expected, got %b", $time, got);
                    flag_mismatches++;
                end else begin
                    want = predicted_flags.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (want[4-i] !== got[4-i]) begin
                            $display("%0t: %s expected %0b actual %0b", $time,
                                     FIELD_NAMES[i], want[4-i], got[4-i]);
                            flag_mismatches++;
                        end
                    end
                end
            end
        end
        flags_outstanding = predicted_flags.size();
    end

endmodule

// ===== tb/vehicle_magnetic_detector_core_test.sv =====
`timescale 1ns / 1ps
// Top of the vehicle magnetic detector testbench: clock, reset, sample stimulus and verdict.
// Depends on vmd_pkg, the detector core and vmd_direction_checker.
module vehicle_magnetic_detector_core_test;
    import vmd_pkg::*;

    localparam int CAL_COUNT   = 40;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN  = -(1 << (SAMPLE_BITS - 1));

    // Length of the receiver's long hold-off, in cycles.
    localparam int HOLD_CYCLES = 120;

    // Idling patterns of the two channels.
    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_mag_sample;
    logic [SAMPLE_BITS-1:0] s_dir_sample;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_calibrating;
    logic                   m_exceeds;
    logic                   m_event_active;
    logic                   m_car_reported;
    logic                   m_direction_in;

    int flag_mismatches;
    int flags_outstanding;

    // Stimulus shaping state shared between the sender and the receiver.
    int sender_idle_pct;
    int receiver_stall_pct;
    bit pressure_request;
    int hold_left;
    int phase_items;

    // The stimulus keeps its own idea of the current settings and of where the
    // baselines sit, so it can aim samples just inside or outside the threshold.
    int thr_now;
    int tout_now;
    int mag_center;
    int dir_center;

    vehicle_magnetic_detector_core #(
        .CAL_COUNT  (CAL_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mag_sample  (s_mag_sample),
        .s_dir_sample  (s_dir_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_calibrating (m_calibrating),
        .m_exceeds     (m_exceeds),
        .m_event_active(m_event_active),
        .m_car_reported(m_car_reported),
        .m_direction_in(m_direction_in)
    );

    vmd_direction_checker #(
        .CAL_COUNT  (CAL_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) flag_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mag_sample     (s_mag_sample),
        .s_dir_sample     (s_dir_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_calibrating    (m_calibrating),
        .m_exceeds        (m_exceeds),
        .m_event_active   (m_event_active),
        .m_car_reported   (m_car_reported),
        .m_direction_in   (m_direction_in),
        .flag_mismatches  (flag_mismatches),
        .flags_outstanding(flags_outstanding)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Receiver. Each falling edge it decides whether to take a result in the
    // next cycle. When the stimulus asks for pressure it refuses results for a
    // long stretch, counted here, so the core fills and drops s_ready while the
    // sender keeps offering samples.
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (pressure_request) begin
                pressure_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // The run should take well under a tenth of this, even in the slowest
    // idling patterns.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Saturate to the sample range so aimed offsets never wrap around.
    function automatic logic [SAMPLE_BITS-1:0] clip_sample(input int v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_BITS'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return SAMPLE_BITS'(SAMPLE_MIN);
        end
        return SAMPLE_BITS'(v);
    endfunction

    // Offer one sample request and hold it until the core accepts it. Inputs
    // change on the falling edge; acceptance is seen at the rising edge. Valid
    // only drops when the sender decides to idle before the next request.
    task automatic offer_sample(input int mag, input int dir);
        @(negedge aclk);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(negedge aclk);
            end while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_valid <= 1'b1;
        s_mag_sample <= clip_sample(mag);
        s_dir_sample <= clip_sample(dir);
        do begin
            @(posedge aclk);
        end while (!s_ready);
        phase_items++;
    endtask

    // Registers only change while the core is idle: stop offering, wait for
    // every expected result, let the pipeline settle, then write all three.
    task automatic apply_settings(input int thr, input int tout, input int gain);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (flags_outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_DEV_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(negedge aclk);
        cfg_addr <= CFG_QUIET_TIMEOUT;
        cfg_wdata <= CFG_DATA_W'(tout);
        @(negedge aclk);
        cfg_addr <= CFG_BASELINE_GAIN;
        cfg_wdata <= CFG_DATA_W'(gain);
        @(negedge aclk);
        cfg_we <= 1'b0;
        thr_now = thr;
        tout_now = tout;
    endtask

    // A sample that stays within the threshold of the baseline, more or less.
    task automatic quiet_sample();
        int span;
        span = (thr_now / 2 > 1000) ? 1000 : thr_now / 2;
        offer_sample(mag_center + int'($urandom_range(0, 2 * span)) - span,
                     dir_center + int'($urandom_range(0, 200)) - 100);
    endtask

    // One stretch of traffic: mostly cars passing (a run of exceeding samples
    // with the direction axis pushed to one side, then a quiet tail that may or
    // may not reach the timeout), plus quiet bursts and raw noise.
    task automatic drive_traffic_sequence();
        int pick;
        int side;
        int dir_side;
        int mag_side;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            offer_sample(int'($urandom_range(0, 65535)) + SAMPLE_MIN,
                         int'($urandom_range(0, 65535)) + SAMPLE_MIN);
        end else if (pick < 40) begin
            repeat ($urandom_range(1, 12)) quiet_sample();
        end else begin
            side = $urandom_range(0, 1) ? 1 : -1;
            repeat ($urandom_range(1, 7)) begin
                mag_side = $urandom_range(0, 1) ? 1 : -1;
                dir_side = ($urandom_range(0, 4) == 0) ? -side : side;
                offer_sample(mag_center + mag_side * (thr_now + 1 +
                                 int'($urandom_range(0, 300))),
                             dir_center + dir_side * int'($urandom_range(0, 4000)));
            end
            repeat ($urandom_range(0, tout_now + 2)) quiet_sample();
        end
    endtask

    task automatic run_phase(input int thr, input int tout, input int gain,
                             input pace_e pace, input int target, input bit squeeze);
        apply_settings(thr, tout, gain);
        case (pace)
            PACE_FULL: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            PACE_SENDER_IDLE: begin
                sender_idle_pct = 88;
                receiver_stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 88;
            end
            default: begin
                sender_idle_pct = 35;
                receiver_stall_pct = 35;
            end
        endcase
        if (squeeze) begin
            pressure_request = 1'b1;
        end
        phase_items = 0;
        while (phase_items < target) begin
            drive_traffic_sequence();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mag_sample = '0;
        s_dir_sample = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        pressure_request = 1'b0;
        phase_items = 0;
        thr_now = THR_RESET;
        tout_now = TOUT_RESET;
        mag_center = int'($urandom_range(0, 2000)) - 1000;
        dir_center = int'($urandom_range(0, 2000)) - 1000;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Calibration runs once, with the reset register values. The two
        // extreme pairs nearly cancel, so the mean lands close to the centers.
        sender_idle_pct = 35;
        receiver_stall_pct = 35;
        offer_sample(SAMPLE_MAX, SAMPLE_MIN);
        offer_sample(SAMPLE_MIN, SAMPLE_MAX);
        repeat (CAL_COUNT - 2) begin
            offer_sample(mag_center + int'($urandom_range(0, 40)) - 20,
                         dir_center + int'($urandom_range(0, 40)) - 20);
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;

        // Directed checks with the reset settings. The first exceeding sample
        // opens the event and puts the previous direction sample in the window;
        // extremes fill the rest, the fourth exceeding sample reports, and the
        // one after that must leave the window alone.
        offer_sample(mag_center, dir_center);
        offer_sample(SAMPLE_MAX, SAMPLE_MAX);
        offer_sample(SAMPLE_MIN, SAMPLE_MIN);
        offer_sample(mag_center + 500, SAMPLE_MAX);
        offer_sample(mag_center - 500, 0);
        offer_sample(mag_center + 500, dir_center);
        repeat (3) offer_sample(mag_center, dir_center);
        offer_sample(mag_center - 900, dir_center);

        // Timeout of one: a single quiet sample ends the event and rearms
        // reporting, so a second car is reported going the other way.
        apply_settings(2, 1, 65535);
        offer_sample(mag_center, dir_center);
        repeat (4) offer_sample(mag_center + 300, dir_center + 3000);
        offer_sample(mag_center, dir_center);
        repeat (4) offer_sample(mag_center - 300, dir_center - 3000);

        // Timeout of zero: every sample that opens the event also closes it.
        apply_settings(2, 0, 65535);
        repeat (5) offer_sample(mag_center + 300, dir_center + 2000);

        // Random traffic through several settings, extremes first. The first
        // phase also carries the long receiver hold-off.
        run_phase(THR_RESET, TOUT_RESET, GAIN_RESET, PACE_FULL, 60, 1'b1);
        run_phase(0, 1, 0, PACE_SENDER_IDLE, 60, 1'b0);
        run_phase(40, 255, 65535, PACE_RECEIVER_STALL, 60, 1'b0);
        run_phase(32767, 0, 1, PACE_BOTH, 60, 1'b0);
        for (int i = 0; i < 4; i++) begin
            run_phase($urandom_range(1, 400), $urandom_range(0, 30), $urandom_range(0, 65535),
                      pace_e'(i % 4), 60, 1'b0);
        end

        // Drain: every expected result must arrive, then the bench waits on
        // to catch any stray result.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (flags_outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(negedge aclk);
        if (flag_mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
